FILE: rtl/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared types and constants for the pinhole depth projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdp_pkg;

  localparam logic OP_PROJECT   = 1'b0;
  localparam logic OP_UNPROJECT = 1'b1;

  localparam int  APB_AW = 4;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FOCAL  = 2'd2;

  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [31:0] FOCAL_RST  = 32'd18718720;

  typedef struct packed {
    logic              op;
    logic signed [31:0] horiz_in;
    logic signed [31:0] vert_in;
    logic signed [31:0] z_meters;
    logic [15:0]       depth_in_mm;
  } pdp_in_t;

  typedef struct packed {
    logic              ok;
    logic signed [31:0] horiz_out;
    logic signed [31:0] vert_out;
    logic [22:0]       z_out;
    logic [15:0]       depth_out_mm;
  } pdp_out_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [31:0] focal;
  } pdp_cfg_t;

  // Per-item control that rides alongside the dividers.
  typedef struct packed {
    logic        valid;
    logic        unproj;
    logic        near;
    logic        fzero;
    logic [22:0] z_out;
    logic [15:0] depth;
  } pdp_side_t;

endpackage

`default_nettype wire

FILE: rtl/pinhole_depth_projection.sv
// ----------------------------------------------------------------------------
// pinhole_depth_projection
// Pinhole depth-camera projection (point to pixel) and unprojection
// (pixel plus millimetre depth to point) in signed fixed point.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------
//   item     | in        | item_valid/item_stall | pdp_in_t
//   result   | out       | result_valid/stall    | pdp_out_t
//   config   | in        | APB psel/penable      | width, height, focal
//
// One item per clock while no held result stalls the pipeline. QB is the larger
// of FRAC_BITS+18 and 33 (34 at the default); the pipeline has five front stages,
// QB+1 stages for the two bit-per-stage dividers and one output stage.
// The divider chain sets the depth.
// Reset is synchronous; it clears the valid bits and loads default geometry.
// A stall on the result side while a result is valid freezes the whole pipeline,
// so item_stall follows it in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_depth_projection #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire pdp_pkg::pdp_in_t           item,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output pdp_pkg::pdp_out_t               result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pdp_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import pdp_pkg::*;

  // Quotient width: wide enough that a clamped quotient still saturates
  // after adding the largest image center.
  localparam int QB  = (FRAC_BITS + 18 > 33) ? FRAC_BITS + 18 : 33;
  localparam int LAT = QB + 1;
  localparam int CW  = FRAC_BITS + 12;
  localparam int SW  = QB + 2;

  pdp_cfg_t           cfg;
  pdp_side_t          f_side;
  logic signed [63:0] num_h, num_v;
  logic [31:0]        den;
  logic [QB-1:0]      mag_h, mag_v;
  logic               neg_h, neg_v;
  logic               en;
  pdp_side_t          side_q [LAT];
  pdp_side_t          sl;

  logic [CW-1:0]         cw, ch;
  logic signed [QB:0]    qh, qv;
  logic signed [SW-1:0]  sum_h, sum_v;
  pdp_out_t              res;

  // Advance everything unless a finished result is held by the sink.
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  pdp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  pdp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en,
    .in_valid (item_valid),
    .in_item  (item),
    .cfg,
    .side     (f_side),
    .num_h, .num_v, .den
  );

  pdp_div #(.QB(QB)) u_div_h (
    .clk, .en, .num(num_h), .den, .mag(mag_h), .neg(neg_h)
  );

  pdp_div #(.QB(QB)) u_div_v (
    .clk, .en, .num(num_v), .den, .mag(mag_v), .neg(neg_v)
  );

  // Carry per-item control in step with the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) side_q[i].valid <= 1'b0;
    end else if (en) begin
      side_q[0] <= f_side;
      for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  assign sl = side_q[LAT-1];

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] smax;
    logic signed [SW-1:0] smin;
    smax = SW'(64'sh7FFF_FFFF);
    smin = -smax - SW'(1);
    if (s > smax)      sat32 = 32'sh7FFF_FFFF;
    else if (s < smin) sat32 = 32'sh8000_0000;
    else               sat32 = s[31:0];
  endfunction

  assign cw = {cfg.width,  {(FRAC_BITS-1){1'b0}}};
  assign ch = {cfg.height, {(FRAC_BITS-1){1'b0}}};

  // Apply the sign, add the image center when projecting, saturate, then drop fields
  // that do not apply to this item.
  always_comb begin
    qh = neg_h ? -$signed({1'b0, mag_h}) : $signed({1'b0, mag_h});
    qv = neg_v ? -$signed({1'b0, mag_v}) : $signed({1'b0, mag_v});
    if (sl.unproj) begin
      sum_h = SW'(qh);
      sum_v = SW'(qv);
    end else begin
      sum_h = SW'($signed({1'b0, cw})) + SW'(qh);
      sum_v = SW'($signed({1'b0, ch})) - SW'(qv);
    end
    res.ok           = sl.unproj || !sl.near;
    res.horiz_out    = sat32(sum_h);
    res.vert_out     = sat32(sum_v);
    res.z_out        = sl.z_out;
    res.depth_out_mm = sl.depth;
    if (sl.unproj && sl.fzero) begin
      res.horiz_out = '0;
      res.vert_out  = '0;
    end
    if (!sl.unproj && sl.near) begin
      res.horiz_out    = '0;
      res.vert_out     = '0;
      res.depth_out_mm = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res;
    end
  end

  // A new result only comes from the end of the divider line.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sl.valid))
    else $error("result appeared without an item at the divider output");

  // A rejected point reports nothing else.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ok) |->
      (result.horiz_out == 32'sd0 && result.vert_out == 32'sd0 &&
       result.depth_out_mm == 16'd0 && result.z_out == 23'd0))
    else $error("rejected point carries nonzero fields");

  // A stalled pipeline holds its first divider stage.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(en) && !$past(rst)) |-> $stable(side_q[0].valid))
    else $error("pipeline moved while stalled");

  // Projection and unprojection never both fill z and depth.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.z_out == 23'd0 || result.depth_out_mm == 16'd0))
    else $error("z and depth both set");

endmodule

`default_nettype wire

FILE: rtl/pdp_regs.sv
// ----------------------------------------------------------------------------
// pdp_regs
// APB-style configuration registers: image width, image height, focal length.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pdp_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output pdp_pkg::pdp_cfg_t               cfg
);
  import pdp_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= WIDTH_RST;
      cfg.height <= HEIGHT_RST;
      cfg.focal  <= FOCAL_RST;
    end else if (wr) begin
      case (idx)
        REG_WIDTH:  cfg.width  <= pwdata[12:0];
        REG_HEIGHT: cfg.height <= pwdata[12:0];
        REG_FOCAL:  cfg.focal  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = {19'd0, cfg.width};
      REG_HEIGHT: prdata = {19'd0, cfg.height};
      REG_FOCAL:  prdata = cfg.focal;
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/pdp_front.sv
// ----------------------------------------------------------------------------
// pdp_front
// Five-stage front end: products, depth conversion and the dividend/divisor
// for the two division lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire pdp_pkg::pdp_in_t   in_item,
  input  wire pdp_pkg::pdp_cfg_t  cfg,
  output pdp_pkg::pdp_side_t      side,
  output logic signed [63:0]      num_h,
  output logic signed [63:0]      num_v,
  output logic [31:0]             den
);
  import pdp_pkg::*;

  localparam int CW = FRAC_BITS + 12;
  localparam int HW = (FRAC_BITS + 13 > 32) ? FRAC_BITS + 14 : 33;
  localparam longint ONE_F = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] NEAR_C = 32'(ONE_F / 1000);
  localparam logic [14:0] ZA_C = 15'(ONE_F / 1000);
  localparam logic [9:0]  ZB_C = 10'(ONE_F % 1000);
  localparam logic [26:0] RECIP = 27'(((64'd1 << 36) + 64'd999) / 64'd1000);

  // stage 1
  logic    v1;
  pdp_in_t r1;
  // stage 2
  logic                     v2, u2, n2, fz2;
  logic [15:0]              dep2;
  logic signed [63:0]       ph2, pv2;
  logic signed [HW-1:0]     hd2, vd2;
  logic [30:0]              ad2;
  logic [25:0]              m2;
  logic [31:0]              zp2;
  // stage 3
  logic                     v3, u3, n3, fz3;
  logic [15:0]              dep3;
  logic signed [63:0]       ph3, pv3;
  logic signed [HW-1:0]     hd3, vd3;
  logic [30:0]              ad3;
  logic [52:0]              pm3;
  logic [31:0]              zp3;
  // stage 4
  logic                     v4, u4, n4, fz4;
  logic [15:0]              dep4;
  logic signed [63:0]       ph4, pv4;
  logic signed [HW-1:0]     hd4, vd4;
  logic [22:0]              zu4;
  logic [31:0]              zp4;

  logic [CW-1:0]        cw, ch;
  logic [41:0]          dsum;
  logic [41:0]          dmm;
  logic signed [HW+23:0] uh, uv;

  assign cw = {cfg.width,  {(FRAC_BITS-1){1'b0}}};
  assign ch = {cfg.height, {(FRAC_BITS-1){1'b0}}};

  // millimetres = z*1000 rounded half up
  assign dsum = 42'(r1.z_meters[30:0]) * 42'd1000 + (42'd1 << (FRAC_BITS - 1));
  assign dmm  = dsum >> FRAC_BITS;

  assign uh = (HW+24)'(hd4) * (HW+24)'($signed({1'b0, zu4}));
  assign uv = (HW+24)'(vd4) * (HW+24)'($signed({1'b0, zu4}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      side.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= in_item;

      u2   <= (r1.op == OP_UNPROJECT);
      n2   <= (r1.z_meters <= NEAR_C);
      fz2  <= (cfg.focal == 32'd0);
      dep2 <= (|dmm[41:16]) ? 16'hFFFF : dmm[15:0];
      ph2  <= 64'(r1.horiz_in) * 64'($signed({1'b0, cfg.focal}));
      pv2  <= 64'(r1.vert_in) * 64'($signed({1'b0, cfg.focal}));
      hd2  <= HW'(r1.horiz_in) - HW'($signed({1'b0, cw}));
      vd2  <= HW'($signed({1'b0, ch})) - HW'(r1.vert_in);
      ad2  <= 31'(ZA_C) * 31'(r1.depth_in_mm);
      m2   <= 26'(ZB_C) * 26'(r1.depth_in_mm) + 26'd500;
      zp2  <= r1.z_meters;

      u3 <= u2; n3 <= n2; fz3 <= fz2; dep3 <= dep2;
      ph3 <= ph2; pv3 <= pv2; hd3 <= hd2; vd3 <= vd2;
      ad3 <= ad2; zp3 <= zp2;
      pm3 <= 53'(m2) * 53'(RECIP);

      u4 <= u3; n4 <= n3; fz4 <= fz3; dep4 <= dep3;
      ph4 <= ph3; pv4 <= pv3; hd4 <= hd3; vd4 <= vd3; zp4 <= zp3;
      zu4 <= 23'(ad3 + 31'(pm3 >> 36));

      side.unproj <= u4;
      side.near   <= n4;
      side.fzero  <= fz4;
      side.z_out  <= u4 ? zu4 : 23'd0;
      side.depth  <= u4 ? 16'd0 : dep4;
      num_h <= u4 ? 64'(uh) : ph4;
      num_v <= u4 ? 64'(uv) : pv4;
      den   <= u4 ? cfg.focal : zp4;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pdp_div.sv
// ----------------------------------------------------------------------------
// pdp_div
// Pipelined restoring divider, one quotient bit per stage, sign-magnitude.
// Quotients that do not fit QB bits come out as all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_div #(
  parameter int QB = 34
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] num,
  input  wire logic [31:0]        den,
  output logic [QB-1:0]           mag,
  output logic                    neg
);
  localparam int HB = 64 - QB;

  logic [31:0]    s_rem [QB+1];
  logic [QB-1:0]  s_low [QB+1];
  logic [QB-1:0]  s_q   [QB+1];
  logic [31:0]    s_den [QB+1];
  logic           s_neg [QB+1];
  logic           s_ovf [QB+1];

  logic [63:0]    a;
  logic [HB-1:0]  hi;

  assign a  = num[63] ? 64'(-num) : 64'(num);
  assign hi = a[63:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem[0] <= 32'(hi);
      s_low[0] <= a[QB-1:0];
      s_q[0]   <= '0;
      s_den[0] <= den;
      s_neg[0] <= num[63];
      s_ovf[0] <= (64'(hi) >= 64'(den));
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [32:0] t;
    logic        ge;
    logic [32:0] diff;

    assign t    = {s_rem[k], s_low[k][QB-1]};
    assign ge   = (t >= {1'b0, s_den[k]});
    assign diff = t - {1'b0, s_den[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k+1] <= ge ? diff[31:0] : t[31:0];
        s_low[k+1] <= s_low[k] << 1;
        s_q[k+1]   <= {s_q[k][QB-2:0], ge};
        s_den[k+1] <= s_den[k];
        s_neg[k+1] <= s_neg[k];
        s_ovf[k+1] <= s_ovf[k];
      end
    end
  end

  assign mag = s_ovf[QB] ? '1 : s_q[QB];
  assign neg = s_neg[QB];

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pinhole_depth_projection: projects and unprojects
// directed and random items under several camera geometries, with random
// idle cycles on both sides, and compares every result against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pdp_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = FB + 25;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pdp_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pdp_out_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Camera geometry as the predictor sees it.
  logic [12:0] cam_width;
  logic [12:0] cam_height;
  logic [31:0] cam_focal;

  pdp_out_t pending_pixels[$];
  int errors = 0;
  longint cycles = 0;

  pinhole_depth_projection #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("** pinhole_depth_projection: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Compute the expected result of one item with the current geometry.
  function automatic pdp_out_t pixel_predict(pdp_in_t it);
    pdp_out_t r;
    longint ctr_u, ctr_v, h, v, f, z, mm;
    longint near_lim;
    r = '0;
    ctr_u = (longint'(cam_width) << FB) >>> 1;
    ctr_v = (longint'(cam_height) << FB) >>> 1;
    h = longint'(it.horiz_in);
    v = longint'(it.vert_in);
    f = longint'({32'd0, cam_focal});
    near_lim = (64'sd1 << FB) / 1000;
    if (it.op == OP_PROJECT) begin
      z = longint'(it.z_meters);
      if (z <= near_lim) return r;
      r.ok = 1'b1;
      r.horiz_out = clamp32(ctr_u + (h * f) / z);
      r.vert_out = clamp32(ctr_v - (v * f) / z);
      mm = (z * 1000 + (64'sd1 << (FB - 1))) >>> FB;
      r.depth_out_mm = (mm > 65535) ? 16'hffff : mm[15:0];
    end else begin
      z = ((longint'(it.depth_in_mm) << FB) + 500) / 1000;
      z = z & 64'h7fffff;
      r.ok = 1'b1;
      r.z_out = z[22:0];
      if (f != 0) begin
        r.horiz_out = clamp32(((h - ctr_u) * z) / f);
        r.vert_out = clamp32(((ctr_v - v) * z) / f);
      end
    end
    return r;
  endfunction

  // Write one register over APB: setup then access.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  cam_width = val[12:0];
      REG_HEIGHT: cam_height = val[12:0];
      REG_FOCAL:  cam_focal = val;
      default: ;
    endcase
  endtask

  // Drop the input, wait for every outstanding result, then let the pipe drain.
  task automatic drain;
    item_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_camera(logic [12:0] w, logic [12:0] hgt, logic [31:0] f);
    drain();
    write_reg(REG_WIDTH, {19'd0, w});
    write_reg(REG_HEIGHT, {19'd0, hgt});
    write_reg(REG_FOCAL, f);
  endtask

  // Send one item after a random gap; hold it until accepted.
  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a zero gap gives back-to-back items.
  task automatic send_item(pdp_in_t it);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_pixels.push_back(pixel_predict(it));
    @(negedge clk);
  endtask

  // Result side: random stall per item, check on acceptance.
  initial begin
    int hold;
    pdp_out_t exp_r;
    @(negedge clk);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_r = pending_pixels.pop_front();
        if (result.ok !== exp_r.ok)
          $display("%0t ok exp %0d got %0d", $time, exp_r.ok, result.ok);
        if (result.horiz_out !== exp_r.horiz_out)
          $display("%0t horiz exp %0d got %0d", $time, exp_r.horiz_out, result.horiz_out);
        if (result.vert_out !== exp_r.vert_out)
          $display("%0t vert exp %0d got %0d", $time, exp_r.vert_out, result.vert_out);
        if (result.z_out !== exp_r.z_out)
          $display("%0t z exp %0d got %0d", $time, exp_r.z_out, result.z_out);
        if (result.depth_out_mm !== exp_r.depth_out_mm)
          $display("%0t depth exp %0d got %0d", $time, exp_r.depth_out_mm,
                   result.depth_out_mm);
        if (result !== exp_r) errors++;
      end
      @(negedge clk);
    end
  end

  function automatic pdp_in_t make_item(logic op, logic [31:0] h, logic [31:0] v,
                                        logic [31:0] z, logic [15:0] d);
    pdp_in_t it;
    it.op = op; it.horiz_in = h; it.vert_in = v; it.z_meters = z;
    it.depth_in_mm = d;
    return it;
  endfunction

  task automatic test_directed;
    send_item(make_item(OP_PROJECT, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 16'd0));
    send_item(make_item(OP_PROJECT, 32'h7fffffff, 32'h80000000, 32'd66, 16'hffff));
    send_item(make_item(OP_PROJECT, 32'h80000000, 32'h7fffffff, 32'd66, 16'd0));
    // Near limit and behind the camera.
    send_item(make_item(OP_PROJECT, 32'h1234, 32'h5678, 32'd65, 16'd0));
    send_item(make_item(OP_PROJECT, 32'hffffffff, 32'hffffffff, 32'd0, 16'd0));
    send_item(make_item(OP_PROJECT, 32'h1234, 32'h5678, 32'h80000000, 16'd0));
    // Depth clamps at the top and rounds half up.
    send_item(make_item(OP_PROJECT, 32'd0, 32'd0, 32'h7fffffff, 16'd0));
    send_item(make_item(OP_PROJECT, 32'd0, 32'd0, 32'h0041_8938, 16'd0));
    send_item(make_item(OP_PROJECT, 32'hffffffff, 32'h1, 32'd67, 16'd0));
    send_item(make_item(OP_UNPROJECT, 32'h0140_0000, 32'h00f0_0000, 32'd0, 16'd1000));
    send_item(make_item(OP_UNPROJECT, 32'h7fffffff, 32'h80000000, 32'hffffffff, 16'hffff));
    send_item(make_item(OP_UNPROJECT, 32'h80000000, 32'h7fffffff, 32'd0, 16'hffff));
    send_item(make_item(OP_UNPROJECT, 32'd0, 32'd0, 32'd0, 16'd0));
    send_item(make_item(OP_UNPROJECT, 32'h1234_5678, 32'h8765_4321, 32'd0, 16'd1));
  endtask

  task automatic test_random(int count);
    pdp_in_t it;
    for (int i = 0; i < count; i++) begin
      it.op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: begin
          it.horiz_in = $urandom; it.vert_in = $urandom; it.z_meters = $urandom;
        end
        default: begin
          // Plausible scene: points within tens of metres, pixels near image.
          it.horiz_in = $signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000;
          it.vert_in = $signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000;
          it.z_meters = $urandom_range(0, 32'h0040_0000);
        end
      endcase
      it.depth_in_mm = 16'($urandom);
      send_item(it);
    end
  endtask

  task automatic test_geometry_sweep;
    set_camera(13'd1, 13'd1, 32'd1);
    test_random(150);
    set_camera(13'd4096, 13'd4096, 32'hffffffff);
    test_random(150);
    set_camera(13'd0, 13'd8191, 32'd0);
    test_directed();
    test_random(100);
    set_camera(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), $urandom);
    test_random(150);
  endtask

  initial begin
    cam_width = WIDTH_RST;
    cam_height = HEIGHT_RST;
    cam_focal = FOCAL_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(800);
    test_geometry_sweep();
    set_camera(WIDTH_RST, HEIGHT_RST, FOCAL_RST);
    test_random(100);
    drain();
    if (errors == 0) begin
      $display("** pinhole_depth_projection: PASSED **");
    end else begin
      $display("** pinhole_depth_projection: FAILED **");
    end
    $finish;
  end

endmodule
